### src/nearest_palette_color_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the palette quantizer
// ---------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("npc check failed");

// antecedent implies consequent in the following cycle
`define NPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("npc check failed");

`endif

### src/npc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color quantizer.
// ---------------------------------------------------------------------------
package npc_pkg;

   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int SLOT_W                = 8;
   localparam int SLOT_SPACE            = 1 << SLOT_W;
   localparam int CHAN_W                = 8;
   localparam int COUNT_W               = 9;
   // max distance is 3*255*255 = 195075, fits in 18 bits
   localparam int DIST_W                = 18;
   // all ones is above any distance, so the first active cell always wins
   localparam logic [DIST_W-1:0] START_BOUND = '1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic              valid;
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [DIST_W-1:0] best_dist;
      logic [SLOT_W-1:0] best_code;
   } item_type;

endpackage

### src/nearest_palette_color_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_palette_color_top
// Nearest palette color quantizer built as a chain of palette cells.
// ---------------------------------------------------------------------------
// Each palette slot lives in its own cell; items walk the chain one cell per
// cycle and one item is accepted every cycle unless the result side stalls;
// a pixel result passes every cell register and then the output register.
// A load item writes its slot when it reaches that cell and produces no
// result; because items never pass each other, pixels see exactly the loads
// that came before them. When the result side stalls the whole chain holds.
// palette_count must be written while the chain is empty; slots searched
// before being loaded return an unspecified code.

`include "nearest_palette_color_top_macros.svh"

module nearest_palette_color_top #(
   parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = entry_index[7:0], red[15:8], green[23:16], blue[31:24]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [npc_pkg::SLOT_W+3*npc_pkg::CHAN_W-1:0] req_tdata,
   // tuser = kind (0 load, 1 pixel)
   input  logic                              req_tuser,
   // response: tdata = palette_code[7:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [npc_pkg::SLOT_W-1:0]        rsp_tdata,
   // palette_count write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [npc_pkg::COUNT_W-1:0]       csr_data
);

   localparam int NUM_CELLS = (PALETTE_DEPTH < npc_pkg::SLOT_SPACE) ?
                              PALETTE_DEPTH : npc_pkg::SLOT_SPACE;

   npc_pkg::item_type                head_item;
   npc_pkg::item_type                chain [0:NUM_CELLS];
   logic                             advance;
   logic [npc_pkg::COUNT_W-1:0]      count_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [npc_pkg::SLOT_W-1:0]       rsp_code_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   always_comb begin
      head_item.valid     = req_tvalid;
      head_item.kind      = req_tuser;
      head_item.slot      = req_tdata[npc_pkg::SLOT_W-1:0];
      head_item.red       = req_tdata[npc_pkg::SLOT_W+npc_pkg::CHAN_W-1:npc_pkg::SLOT_W];
      head_item.green     = req_tdata[npc_pkg::SLOT_W+2*npc_pkg::CHAN_W-1:
                                      npc_pkg::SLOT_W+npc_pkg::CHAN_W];
      head_item.blue      = req_tdata[npc_pkg::SLOT_W+3*npc_pkg::CHAN_W-1:
                                      npc_pkg::SLOT_W+2*npc_pkg::CHAN_W];
      head_item.best_dist = npc_pkg::START_BOUND;
      head_item.best_code = '0;
   end

   assign chain[0] = head_item;

   for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
      npc_cell #(
         .CELL_INDEX(c)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance_i (advance),
         .count_i   (count_ff),
         .item_i    (chain[c]),
         .item_o    (chain[c+1])
      );
   end

   assign rsp_valid_in = chain[NUM_CELLS].valid
                         && (chain[NUM_CELLS].kind == npc_pkg::KIND_PIXEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_code_ff <= chain[NUM_CELLS].best_code;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;

   // a searched pixel always lands inside the configured range
   `NPC_ASSERT_SAME(a_code_in_range, clock, reset,
      rsp_valid_ff && count_ff != '0, {1'b0, rsp_code_ff} < count_ff)
   // empty palette answers slot zero
   `NPC_ASSERT_SAME(a_empty_zero, clock, reset,
      rsp_valid_ff && count_ff == '0, rsp_code_ff == '0)
   // a load leaving the chain must not turn into a result
   `NPC_ASSERT_NEXT(a_load_silent, clock, reset,
      advance && chain[NUM_CELLS].valid && chain[NUM_CELLS].kind == npc_pkg::KIND_LOAD,
      !rsp_valid_ff)

endmodule

### src/npc_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// npc_cell
// One palette slot: holds its entry, updates the running best for pixels.
// ---------------------------------------------------------------------------
module npc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance_i,
   input  logic [npc_pkg::COUNT_W-1:0]    count_i,
   input  npc_pkg::item_type              item_i,
   output npc_pkg::item_type              item_o
);

   localparam logic [npc_pkg::SLOT_W-1:0] CELL_SLOT = npc_pkg::SLOT_W'(CELL_INDEX);

   npc_pkg::item_type                     item_ff;
   npc_pkg::item_type                     item_in;
   logic [3*npc_pkg::CHAN_W-1:0]          entry_ff;

   logic [npc_pkg::CHAN_W-1:0]            diff_r;
   logic [npc_pkg::CHAN_W-1:0]            diff_g;
   logic [npc_pkg::CHAN_W-1:0]            diff_b;
   logic [npc_pkg::DIST_W-1:0]            pixel_dist;
   logic                                  active;
   logic                                  load_hit;

   function automatic logic [npc_pkg::CHAN_W-1:0] abs_diff(
      input logic [npc_pkg::CHAN_W-1:0] a,
      input logic [npc_pkg::CHAN_W-1:0] b
   );
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   assign diff_r = abs_diff(item_i.red,   entry_ff[3*npc_pkg::CHAN_W-1:2*npc_pkg::CHAN_W]);
   assign diff_g = abs_diff(item_i.green, entry_ff[2*npc_pkg::CHAN_W-1:npc_pkg::CHAN_W]);
   assign diff_b = abs_diff(item_i.blue,  entry_ff[npc_pkg::CHAN_W-1:0]);

   assign pixel_dist = npc_pkg::DIST_W'(diff_r * diff_r)
                     + npc_pkg::DIST_W'(diff_g * diff_g)
                     + npc_pkg::DIST_W'(diff_b * diff_b);

   assign active   = {1'b0, CELL_SLOT} < count_i;
   assign load_hit = item_i.valid && (item_i.kind == npc_pkg::KIND_LOAD)
                     && (item_i.slot == CELL_SLOT);

   always_comb begin
      item_in = item_i;
      // strict compare keeps the lower slot on a tie
      if (item_i.kind == npc_pkg::KIND_PIXEL && active && pixel_dist < item_i.best_dist) begin
         item_in.best_dist = pixel_dist;
         item_in.best_code = CELL_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance_i) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance_i && load_hit) begin
         entry_ff <= {item_i.red, item_i.green, item_i.blue};
      end
   end

   assign item_o = item_ff;

endmodule

### sim/nearest_color_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_color_checker
// Watches the request, result and palette_count channels of the palette
// quantizer. It keeps its own palette copy, works out the expected code for
// each accepted pixel, and compares the results in order.
// ---------------------------------------------------------------------------
module nearest_color_checker
   import npc_pkg::*;
#(
   parameter int DEPTH = PALETTE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   // tdata = entry_index, red, green, blue (lowest bit up)
   input  logic [SLOT_W+3*CHAN_W-1:0]   req_tdata,
   // tuser = kind
   input  logic                         req_tuser,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // tdata = palette_code
   input  logic [SLOT_W-1:0]            rsp_tdata,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [COUNT_W-1:0]           csr_data,
   output int                           pending,
   output int                           checked,
   output int                           errors
);

   // above 3*255*255, so the first searched entry always wins
   localparam int SEARCH_BOUND = 300 << 16;

   logic [3*CHAN_W-1:0] palette_copy [DEPTH];
   logic [COUNT_W-1:0]  search_count;
   logic [SLOT_W-1:0]   code_q [$];

   function automatic int sq_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   function automatic logic [SLOT_W-1:0] closest_entry(logic [CHAN_W-1:0] r, g, b);
      int lim;
      int best_dist;
      int gap_sum;
      int c;
      logic [SLOT_W-1:0] best;
      logic [3*CHAN_W-1:0] e;
      lim = int'(search_count);
      if (lim > DEPTH) lim = DEPTH;
      if (lim > SLOT_SPACE) lim = SLOT_SPACE;
      best = '0;
      best_dist = SEARCH_BOUND;
      for (c = 0; c < lim; c++) begin
         e = palette_copy[c];
         gap_sum = sq_gap(r, e[23:16]) + sq_gap(g, e[15:8]) + sq_gap(b, e[7:0]);
         // strict compare: the lowest index keeps a tie
         if (gap_sum < best_dist) begin
            best_dist = gap_sum;
            best = c[SLOT_W-1:0];
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      logic [SLOT_W-1:0] slot;
      logic [CHAN_W-1:0] r, g, b;
      logic [SLOT_W-1:0] want;
      if (reset) begin
         code_q.delete();
         search_count = '0;
         foreach (palette_copy[i]) palette_copy[i] = '0;
         checked = 0;
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) search_count = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (code_q.size() == 0) begin
               $error("palette_code: unexpected result, expected none, actual %0d",
                      rsp_tdata);
               errors++;
            end else begin
               want = code_q.pop_front();
               checked++;
               if (rsp_tdata !== want) begin
                  $error("palette_code mismatch: expected %0d, actual %0d", want, rsp_tdata);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            slot = req_tdata[SLOT_W-1:0];
            r    = req_tdata[SLOT_W +: CHAN_W];
            g    = req_tdata[SLOT_W+CHAN_W +: CHAN_W];
            b    = req_tdata[SLOT_W+2*CHAN_W +: CHAN_W];
            if (req_tuser == KIND_LOAD) begin
               if (slot < DEPTH) palette_copy[slot] = {r, g, b};
            end else begin
               code_q.push_back(closest_entry(r, g, b));
            end
         end
      end
      pending = code_q.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the nearest palette color quantizer: directed palette and
// pixel items, a full palette fill, then random phases over several
// palette_count settings with sender gaps, result stalls and one long
// result-side hold. Checking is done by nearest_color_checker.
// ---------------------------------------------------------------------------
module tb;
   import npc_pkg::*;

   localparam int CHAIN_LAT = 257;   // palette cells plus output register
   localparam int LONG_HOLD = 1500;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [SLOT_W+3*CHAN_W-1:0] req_tdata;   // entry_index, red, green, blue
   logic                       req_tuser;   // kind
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [SLOT_W-1:0]          rsp_tdata;   // palette_code
   logic                       csr_valid;
   logic                       csr_ready;
   logic [COUNT_W-1:0]         csr_data;

   int pending, checked, errors;
   int idle_pct, stall_pct;
   bit hold_request;
   int loads_sent, pixels_sent, settings;
   int cur_count;
   logic [3*CHAN_W-1:0] shade [SLOT_SPACE];   // colors loaded so far, for shaping pixels

   nearest_palette_color_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   nearest_color_checker code_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .pending    (pending),
      .checked    (checked),
      .errors     (errors)
   );

   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

   // result side: random stalls, or one long hold when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // called and returns at a falling edge; valid stays high for a following item
   task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic [3*CHAN_W-1:0] rgb);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], slot};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (kind == KIND_LOAD) begin
         shade[slot] = rgb;
         loads_sent++;
      end else begin
         pixels_sent++;
      end
   endtask

   // wait for every code, then let trailing loads leave the chain
   task automatic drain();
      req_tvalid <= 1'b0;
      stall_pct = 0;
      while (pending != 0) @(negedge clock);
      repeat (CHAIN_LAT + 16) @(negedge clock);
   endtask

   task automatic write_count(input int value);
      csr_valid <= 1'b1;
      csr_data  <= value[COUNT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_count = value;
      settings++;
   endtask

   function automatic logic [3*CHAN_W-1:0] load_color();
      // copies of existing entries make ties
      if ($urandom_range(0, 3) == 0) return shade[$urandom_range(0, SLOT_SPACE - 1)];
      return 24'($urandom_range(0, 24'hFFFFFF));
   endfunction

   function automatic logic [3*CHAN_W-1:0] pick_pixel();
      int lim;
      int k;
      int v;
      logic [3*CHAN_W-1:0] base;
      logic [3*CHAN_W-1:0] rgb;
      lim = (cur_count > SLOT_SPACE) ? SLOT_SPACE : cur_count;
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      if (lim == 0 || $urandom_range(0, 1) == 0) return 24'($urandom_range(0, 24'hFFFFFF));
      // near an active entry, so small distance differences decide
      base = shade[$urandom_range(0, lim - 1)];
      for (k = 0; k < 3; k++) begin
         v = int'(base[8*k +: 8]) + int'($urandom_range(0, 6)) - 3;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         rgb[8*k +: 8] = v[7:0];
      end
      return rgb;
   endfunction

   task automatic run_phase(input int count, input int idle, input int stall,
                            input int items);
      drain();
      write_count(count);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (items) begin
         if ($urandom_range(0, 3) == 0)
            send_item(KIND_LOAD, SLOT_W'($urandom_range(0, SLOT_SPACE - 1)), load_color());
         else
            send_item(KIND_PIXEL, SLOT_W'($urandom_range(0, SLOT_SPACE - 1)), pick_pixel());
      end
      drain();
   endtask

   initial begin
      int i;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = KIND_LOAD;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      idle_pct     = 0;
      stall_pct    = 0;
      hold_request = 1'b0;
      loads_sent   = 0;
      pixels_sent  = 0;
      settings     = 0;
      cur_count    = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // count is zero out of reset: every pixel maps to code 0
      send_item(KIND_PIXEL, 8'h00, 24'h000000);
      send_item(KIND_PIXEL, 8'hFF, 24'hFFFFFF);
      send_item(KIND_PIXEL, 8'h5A, 24'h55AA0F);
      send_item(KIND_LOAD, 8'h00, 24'h000000);
      send_item(KIND_LOAD, 8'h01, 24'hFFFFFF);
      send_item(KIND_LOAD, 8'h02, 24'h8040C8);
      send_item(KIND_LOAD, 8'h03, 24'h8040C8);   // same as slot 2: tie goes to 2
      send_item(KIND_LOAD, 8'hFF, 24'hAA55F0);
      drain();
      write_count(4);
      send_item(KIND_PIXEL, 8'h00, 24'h000000);
      send_item(KIND_PIXEL, 8'hFF, 24'hFFFFFF);
      send_item(KIND_PIXEL, 8'h33, 24'h8040C8);
      send_item(KIND_PIXEL, 8'hC3, 24'h8141C7);
      send_item(KIND_PIXEL, 8'h01, 24'h7F7F7F);
      send_item(KIND_PIXEL, 8'h80, 24'h808080);
      send_item(KIND_PIXEL, 8'h7E, 24'hFF0000);
      send_item(KIND_PIXEL, 8'h55, 24'h00FF00);
      send_item(KIND_PIXEL, 8'hAA, 24'h0000FF);

      // fill every slot so any count may be searched
      for (i = 0; i < SLOT_SPACE; i++) begin
         if (i > 0 && $urandom_range(0, 7) == 0)
            send_item(KIND_LOAD, i[SLOT_W-1:0], shade[$urandom_range(0, i - 1)]);
         else
            send_item(KIND_LOAD, i[SLOT_W-1:0], 24'($urandom_range(0, 24'hFFFFFF)));
      end

      run_phase(SLOT_SPACE, 0, 0, 300);
      run_phase($urandom_range(2, SLOT_SPACE - 2), 63, 0, 250);
      run_phase(1, 0, 63, 200);
      run_phase(SLOT_SPACE, 12, 12, 250);
      run_phase(0, 12, 12, 60);
      run_phase(SLOT_SPACE - 1, 63, 63, 150);

      // long result hold while pixels keep coming: the chain fills and stalls
      drain();
      write_count(128);
      idle_pct = 0;
      hold_request = 1'b1;
      repeat (400)
         send_item(KIND_PIXEL, SLOT_W'($urandom_range(0, SLOT_SPACE - 1)), pick_pixel());
      drain();

      $display("Run covered %0d palette loads and %0d pixels over %0d count settings,",
               loads_sent, pixels_sent, settings);
      $display("with %0d codes compared, sender gaps, result stalls and one long hold.",
               checked);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
